// ===== rtl/dtpq_pkg.sv =====
// Shared types and constants for the drop-tail packet queue.
`timescale 1ns / 1ps
`default_nettype none

package dtpq_pkg;

  // Field widths fixed by the interface
  localparam int HANDLE_W  = 16;
  localparam int LENGTH_W  = 16;
  localparam int LIMIT_W   = 7;
  localparam int OCC_W     = 7;
  localparam int PKTCNT_W  = 32;
  localparam int BYTECNT_W = 48;

  // Queue limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd50;

  typedef enum logic [2:0] {
    MODE_ENQUEUE   = 3'd0,
    MODE_DEQUEUE   = 3'd1,
    MODE_PEEK      = 3'd2,
    MODE_FLUSH     = 3'd3,
    MODE_ACC_SENT  = 3'd4,
    MODE_ACC_DROP  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_t;

  // Input transfer
  typedef struct packed {
    mode_t                mode;
    logic [HANDLE_W-1:0]  packet_handle;
    logic [LENGTH_W-1:0]  packet_length;
  } in_item_t;

  // Result transfer
  typedef struct packed {
    status_t               status;
    logic [HANDLE_W-1:0]   head_handle;
    logic [LENGTH_W-1:0]   head_length;
    logic [OCC_W-1:0]      occupancy;
    logic [PKTCNT_W-1:0]   sent_packets;
    logic [BYTECNT_W-1:0]  sent_bytes;
    logic [PKTCNT_W-1:0]   dropped_packets;
    logic [BYTECNT_W-1:0]  dropped_bytes;
  } out_item_t;

  // Ring store controls
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_ctrl_t;

  // Counter controls
  typedef struct packed {
    logic add_sent;
    logic add_drop;
  } stats_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/drop_tail_packet_queue_top.sv =====
// Top level of the drop-tail packet queue: input register, decode and result register.
//
//   Channel  Direction  Handshake              Payload
//   in       to block   in_valid / in_ready    in_item  (mode, handle, length)
//   out      from block out_valid / out_ready  out_item (status, head, occupancy, counters)
//   cfg      to block   cfg_wr_en              cfg_wr_data (queue limit)
//
// One item per cycle unless the output stalls; in_q and out_item register each item.
// The head entry is prefetched from the ring store into a register, so a dequeue or
// peek needs no extra read, even straight after an enqueue to an empty queue.
// Synchronous reset empties the queue, clears all counters and sets the limit to 50.
// A stalled output holds the result; the input register then takes one more item.
`timescale 1ns / 1ps
`default_nettype none

module drop_tail_packet_queue_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int LENGTH_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  dtpq_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output dtpq_pkg::out_item_t                  out_item,
  input  wire                                  cfg_wr_en,
  input  wire  [dtpq_pkg::LIMIT_W-1:0]         cfg_wr_data
);

  localparam int LW    = dtpq_pkg::LENGTH_W;
  localparam int SLW   = (LENGTH_BITS < LW) ? LENGTH_BITS : LW;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CW    = (CNT_W > dtpq_pkg::LIMIT_W) ? CNT_W : dtpq_pkg::LIMIT_W;
  localparam int OW    = dtpq_pkg::OCC_W;

  // Input register
  dtpq_pkg::in_item_t  in_q;
  logic                in_full;
  logic                fire;

  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  // Queue limit register
  logic [dtpq_pkg::LIMIT_W-1:0] limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= dtpq_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  // Ring store and counters
  dtpq_pkg::ring_ctrl_t           ring_ctrl;
  dtpq_pkg::stats_ctrl_t          stats_ctrl;
  logic [SLW-1:0]                 len_in;
  logic [dtpq_pkg::HANDLE_W-1:0]  head_handle;
  logic [SLW-1:0]                 head_length;
  logic [CNT_W-1:0]               count, count_next;
  logic [LW-1:0]                  stat_len;
  logic [dtpq_pkg::PKTCNT_W-1:0]  sent_pkts_next, drop_pkts_next;
  logic [dtpq_pkg::BYTECNT_W-1:0] sent_bytes_next, drop_octets_next;

  assign len_in = in_q.packet_length[SLW-1:0];

  dtpq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .LEN_W (SLW)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ring_ctrl),
    .wr_handle   (in_q.packet_handle),
    .wr_length   (len_in),
    .head_handle (head_handle),
    .head_length (head_length),
    .count       (count),
    .count_next  (count_next)
  );

  dtpq_stats u_stats (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (stats_ctrl),
    .len              (stat_len),
    .sent_pkts_next   (sent_pkts_next),
    .sent_bytes_next  (sent_bytes_next),
    .drop_pkts_next   (drop_pkts_next),
    .drop_octets_next (drop_octets_next)
  );

  // Admission check against the limit saturated to the store depth
  logic [CW-1:0] lim_ext, eff_limit;
  logic          at_limit, empty;

  assign lim_ext   = CW'(limit);
  assign eff_limit = (lim_ext > CW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : lim_ext;
  assign at_limit  = CW'(count) >= eff_limit;
  assign empty     = (count == '0);

  // Mode decode
  dtpq_pkg::status_t              status;
  logic [dtpq_pkg::HANDLE_W-1:0]  res_handle;
  logic [LW-1:0]                  res_length;

  always_comb begin
    ring_ctrl  = '0;
    stats_ctrl = '0;
    stat_len   = LW'(len_in);
    status     = dtpq_pkg::STATUS_DONE;
    res_handle = '0;
    res_length = '0;
    unique case (in_q.mode)
      dtpq_pkg::MODE_ENQUEUE: begin
        if (at_limit) begin
          status              = dtpq_pkg::STATUS_DROPPED;
          stats_ctrl.add_drop = fire;
        end else begin
          ring_ctrl.push = fire;
        end
      end
      dtpq_pkg::MODE_DEQUEUE: begin
        if (empty) begin
          status = dtpq_pkg::STATUS_EMPTY;
        end else begin
          res_handle          = head_handle;
          res_length          = LW'(head_length);
          ring_ctrl.pop       = fire;
          stats_ctrl.add_sent = fire;
          stat_len            = LW'(head_length);
        end
      end
      dtpq_pkg::MODE_PEEK: begin
        if (empty) begin
          status = dtpq_pkg::STATUS_EMPTY;
        end else begin
          res_handle = head_handle;
          res_length = LW'(head_length);
        end
      end
      dtpq_pkg::MODE_FLUSH: begin
        ring_ctrl.flush = fire;
      end
      dtpq_pkg::MODE_ACC_SENT: begin
        stats_ctrl.add_sent = fire;
      end
      dtpq_pkg::MODE_ACC_DROP: begin
        stats_ctrl.add_drop = fire;
      end
      default: begin
        // unused modes change nothing
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.status          <= status;
      out_item.head_handle     <= res_handle;
      out_item.head_length     <= res_length;
      out_item.occupancy       <= OW'(count_next);
      out_item.sent_packets    <= sent_pkts_next;
      out_item.sent_bytes      <= sent_bytes_next;
      out_item.dropped_packets <= drop_pkts_next;
      out_item.dropped_bytes   <= drop_octets_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dtpq_ring.sv =====
// Descriptor ring store with pointers, fill count and prefetched head entry.
`timescale 1ns / 1ps
`default_nettype none

module dtpq_ring #(
  parameter int DEPTH = 64,
  parameter int LEN_W = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  dtpq_pkg::ring_ctrl_t               ctrl,
  input  wire  [dtpq_pkg::HANDLE_W-1:0]      wr_handle,
  input  wire  [LEN_W-1:0]                   wr_length,
  output logic [dtpq_pkg::HANDLE_W-1:0]      head_handle,
  output logic [LEN_W-1:0]                   head_length,
  output logic [$clog2(DEPTH+1)-1:0]         count,
  output logic [$clog2(DEPTH+1)-1:0]         count_next
);

  localparam int PW    = $clog2(DEPTH);
  localparam int ENT_W = dtpq_pkg::HANDLE_W + LEN_W;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] head;
  logic [PW-1:0]    rd_ptr, rd_ptr_next;
  logic [PW-1:0]    wr_ptr, wr_ptr_next;

  // Pointer and count updates
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    if (ctrl.flush) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
      count_next  = '0;
    end else begin
      if (ctrl.push) begin
        wr_ptr_next = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
        count_next  = count + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr_next = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
        count_next  = count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= {wr_handle, wr_length};
    end
  end

  // Head read port, looking at the next head; a write to that slot passes straight through
  always_ff @(posedge clk) begin
    if (ctrl.push && (wr_ptr == rd_ptr_next)) begin
      head <= {wr_handle, wr_length};
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

  assign head_handle = head[ENT_W-1:LEN_W];
  assign head_length = head[LEN_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/dtpq_stats.sv =====
// Wrapping sent and dropped packet and byte counters.
`timescale 1ns / 1ps
`default_nettype none

module dtpq_stats (
  input  wire                                 clk,
  input  wire                                 rst,
  input  dtpq_pkg::stats_ctrl_t               ctrl,
  input  wire  [dtpq_pkg::LENGTH_W-1:0]       len,
  output logic [dtpq_pkg::PKTCNT_W-1:0]       sent_pkts_next,
  output logic [dtpq_pkg::BYTECNT_W-1:0]      sent_bytes_next,
  output logic [dtpq_pkg::PKTCNT_W-1:0]       drop_pkts_next,
  output logic [dtpq_pkg::BYTECNT_W-1:0]      drop_octets_next
);

  localparam int BW = dtpq_pkg::BYTECNT_W;

  logic [dtpq_pkg::PKTCNT_W-1:0]  sent_pkts, drop_pkts;
  logic [BW-1:0]                  sent_bytes, drop_octets;

  // Next counter values; all wrap at their width
  always_comb begin
    sent_pkts_next   = sent_pkts;
    sent_bytes_next  = sent_bytes;
    drop_pkts_next   = drop_pkts;
    drop_octets_next = drop_octets;
    if (ctrl.add_sent) begin
      sent_pkts_next  = sent_pkts + 1'b1;
      sent_bytes_next = sent_bytes + BW'(len);
    end
    if (ctrl.add_drop) begin
      drop_pkts_next   = drop_pkts + 1'b1;
      drop_octets_next = drop_octets + BW'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_pkts   <= '0;
      sent_bytes  <= '0;
      drop_pkts   <= '0;
      drop_octets <= '0;
    end else begin
      sent_pkts   <= sent_pkts_next;
      sent_bytes  <= sent_bytes_next;
      drop_pkts   <= drop_pkts_next;
      drop_octets <= drop_octets_next;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_drop_tail_packet_queue_top.sv =====
// Self-checking testbench for the drop-tail packet descriptor queue: random and directed traffic.
`timescale 1ns / 1ps

module tb_drop_tail_packet_queue_top;

  localparam int RING_DEPTH = 64;
  // Spare mode codes, not in mode_t; the block must treat them as no-ops
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dtpq_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dtpq_pkg::out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [dtpq_pkg::LIMIT_W-1:0] cfg_wr_data = '0;

  drop_tail_packet_queue_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Descriptor ops waiting to be driven, and results still owed by the block
  dtpq_pkg::in_item_t  descriptor_ops[$];
  dtpq_pkg::out_item_t expected_reports[$];

  int mismatches = 0;
  int ops_planned = 0;
  int ops_accepted = 0;
  int reports_seen = 0;
  logic calm;

  // Stretch in the middle of the run without random idles or stalls
  assign calm = (ops_accepted >= 600) && (ops_accepted < 800);

  // Queue model state
  logic [dtpq_pkg::HANDLE_W-1:0]  handle_ring [RING_DEPTH];
  logic [dtpq_pkg::LENGTH_W-1:0]  length_ring [RING_DEPTH];
  int                             head_idx = 0;
  int                             tail_idx = 0;
  int                             held = 0;
  logic [dtpq_pkg::PKTCNT_W-1:0]  sent_pkts = '0;
  logic [dtpq_pkg::BYTECNT_W-1:0] sent_octets = '0;
  logic [dtpq_pkg::PKTCNT_W-1:0]  drop_pkts = '0;
  logic [dtpq_pkg::BYTECNT_W-1:0] drop_octets = '0;
  logic [dtpq_pkg::LIMIT_W-1:0]   limit_model = dtpq_pkg::LIMIT_RESET;

  // Apply one descriptor op to the queue model and return the report it should give
  function automatic dtpq_pkg::out_item_t apply_queue_op(dtpq_pkg::in_item_t op);
    dtpq_pkg::out_item_t rep;
    int eff_limit;
    rep = '0;
    rep.status = dtpq_pkg::STATUS_DONE;
    eff_limit = (limit_model > RING_DEPTH) ? RING_DEPTH : int'(limit_model);
    case (op.mode)
      dtpq_pkg::MODE_ENQUEUE: begin
        if (held >= eff_limit) begin
          drop_pkts = drop_pkts + 1;
          drop_octets = drop_octets + op.packet_length;
          rep.status = dtpq_pkg::STATUS_DROPPED;
        end else begin
          handle_ring[tail_idx] = op.packet_handle;
          length_ring[tail_idx] = op.packet_length;
          tail_idx = (tail_idx + 1) % RING_DEPTH;
          held = held + 1;
        end
      end
      dtpq_pkg::MODE_DEQUEUE, dtpq_pkg::MODE_PEEK: begin
        if (held == 0) begin
          rep.status = dtpq_pkg::STATUS_EMPTY;
        end else begin
          rep.head_handle = handle_ring[head_idx];
          rep.head_length = length_ring[head_idx];
          if (op.mode == dtpq_pkg::MODE_DEQUEUE) begin
            head_idx = (head_idx + 1) % RING_DEPTH;
            held = held - 1;
            sent_pkts = sent_pkts + 1;
            sent_octets = sent_octets + rep.head_length;
          end
        end
      end
      dtpq_pkg::MODE_FLUSH: begin
        head_idx = 0;
        tail_idx = 0;
        held = 0;
      end
      dtpq_pkg::MODE_ACC_SENT: begin
        sent_pkts = sent_pkts + 1;
        sent_octets = sent_octets + op.packet_length;
      end
      dtpq_pkg::MODE_ACC_DROP: begin
        drop_pkts = drop_pkts + 1;
        drop_octets = drop_octets + op.packet_length;
      end
      default: ;
    endcase
    rep.occupancy = held[dtpq_pkg::OCC_W-1:0];
    rep.sent_packets = sent_pkts;
    rep.sent_bytes = sent_octets;
    rep.dropped_packets = drop_pkts;
    rep.dropped_bytes = drop_octets;
    return rep;
  endfunction

  // Sender: valid held with a stable payload until the transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(apply_queue_op(in_item));
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (descriptor_ops.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
          in_valid <= 1'b1;
          in_item <= descriptor_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  int hold_left = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && reports_seen >= 400) begin
      hold_left <= 200;
      long_hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 23);
    end
  end

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: each result transfer against the oldest expectation
  always @(posedge clk) begin
    dtpq_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      reports_seen <= reports_seen + 1;
      if (expected_reports.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("head_handle", want.head_handle, out_item.head_handle);
        check_field("head_length", want.head_length, out_item.head_length);
        check_field("occupancy", want.occupancy, out_item.occupancy);
        check_field("sent_packets", want.sent_packets, out_item.sent_packets);
        check_field("sent_bytes", want.sent_bytes, out_item.sent_bytes);
        check_field("dropped_packets", want.dropped_packets, out_item.dropped_packets);
        check_field("dropped_bytes", want.dropped_bytes, out_item.dropped_bytes);
      end
    end
  end

  task automatic push_op(logic [2:0] m, logic [15:0] h, logic [15:0] l);
    dtpq_pkg::in_item_t op;
    op.mode = dtpq_pkg::mode_t'(m);
    op.packet_handle = h;
    op.packet_length = l;
    descriptor_ops.push_back(op);
    ops_planned++;
  endtask

  // Field value with a bias towards the extremes
  function automatic logic [15:0] pick_field();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Only written while the block is idle
  task automatic write_limit(logic [dtpq_pkg::LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    limit_model = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (descriptor_ops.size() != 0 || in_valid || expected_reports.size() != 0);
  endtask

  // Mostly enqueue and dequeue bursts so occupancy swings between empty and the limit
  task automatic random_traffic(int n);
    int target;
    int r;
    int burst;
    target = ops_planned + n;
    while (ops_planned < target) begin
      r = $urandom_range(0, 99);
      burst = (r < 12) ? $urandom_range(40, 70) : $urandom_range(1, 12);
      if (burst > target - ops_planned) burst = target - ops_planned;
      if (r < 40) begin
        repeat (burst) push_op(dtpq_pkg::MODE_ENQUEUE, pick_field(), pick_field());
      end else if (r < 70) begin
        repeat (burst)
          push_op(($urandom_range(0, 3) == 0) ? dtpq_pkg::MODE_PEEK : dtpq_pkg::MODE_DEQUEUE,
                  pick_field(), pick_field());
      end else if (r < 74) begin
        push_op(dtpq_pkg::MODE_FLUSH, pick_field(), pick_field());
      end else if (r < 82) begin
        push_op(($urandom_range(0, 1) == 0) ? dtpq_pkg::MODE_ACC_SENT : dtpq_pkg::MODE_ACC_DROP,
                pick_field(), pick_field());
      end else if (r < 85) begin
        push_op(($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI,
                pick_field(), pick_field());
      end else begin
        push_op(3'($urandom_range(0, 7)), pick_field(), pick_field());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty queue, full queue with a limit of two, extremes, accumulate, flush, spare modes
    write_limit(7'd2);
    push_op(dtpq_pkg::MODE_DEQUEUE, 16'h0001, 16'h0001);
    push_op(dtpq_pkg::MODE_PEEK, 16'h0002, 16'h0002);
    push_op(dtpq_pkg::MODE_ENQUEUE, 16'h0000, 16'h0000);
    push_op(dtpq_pkg::MODE_ENQUEUE, 16'hFFFF, 16'hFFFF);
    push_op(dtpq_pkg::MODE_ENQUEUE, 16'h1234, 16'hFFFF);
    push_op(dtpq_pkg::MODE_PEEK, 16'h0000, 16'h0000);
    push_op(dtpq_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000);
    push_op(dtpq_pkg::MODE_DEQUEUE, 16'hFFFF, 16'hFFFF);
    push_op(dtpq_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000);
    push_op(dtpq_pkg::MODE_ACC_SENT, 16'h0000, 16'hFFFF);
    push_op(dtpq_pkg::MODE_ACC_DROP, 16'hFFFF, 16'h0000);
    push_op(dtpq_pkg::MODE_ACC_DROP, 16'h5A5A, 16'hFFFF);
    push_op(dtpq_pkg::MODE_ENQUEUE, 16'hA5A5, 16'h5A5A);
    push_op(dtpq_pkg::MODE_FLUSH, 16'h0000, 16'h0000);
    push_op(dtpq_pkg::MODE_PEEK, 16'h0000, 16'h0000);
    push_op(MODE_SPARE_LO, 16'hFFFF, 16'hFFFF);
    push_op(MODE_SPARE_HI, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // Zero limit drops every arrival
    write_limit(7'd0);
    push_op(dtpq_pkg::MODE_ENQUEUE, 16'hFFFF, 16'hFFFF);
    push_op(dtpq_pkg::MODE_ENQUEUE, 16'h0000, 16'h8001);
    push_op(dtpq_pkg::MODE_DEQUEUE, 16'h0000, 16'h0000);
    wait_drained();

    // Random phases: oversized, store-sized, just over, one, mid and reset limits
    write_limit(7'd127);
    random_traffic(172);
    wait_drained();
    write_limit(7'd64);
    random_traffic(172);
    wait_drained();
    write_limit(7'd65);
    random_traffic(172);
    wait_drained();
    write_limit(7'd1);
    random_traffic(172);
    wait_drained();
    write_limit(7'($urandom_range(2, 63)));
    random_traffic(172);
    wait_drained();
    write_limit(dtpq_pkg::LIMIT_RESET);
    random_traffic(172);
    wait_drained();

    // Let the pipeline settle, then judge
    repeat (10) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d results never arrived", expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
